// File: src/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// types, widths and cordic constants shared by the polar vector add/sub block
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int unsigned MAG_W      = 24;
  localparam int unsigned ANG_W      = 16;
  localparam int unsigned RMAG_W     = 25;
  localparam int unsigned GUARD      = 6;
  localparam int unsigned CW         = 33;
  localparam int unsigned ZR_W       = 33;
  localparam int unsigned SW         = 34;
  localparam int unsigned VW         = 35;
  localparam int unsigned ZV_W       = 34;
  localparam int unsigned AT_W       = 30;
  localparam int unsigned MAX_STAGES = 24;
  localparam int unsigned MAGC_W     = 33;
  localparam int unsigned LO_W       = 17;

  localparam logic [ANG_W-1:0] ANG_0   = 16'h0000;
  localparam logic [ANG_W-1:0] ANG_90  = 16'h4000;
  localparam logic [ANG_W-1:0] ANG_180 = 16'h8000;
  localparam logic [ANG_W-1:0] ANG_270 = 16'hC000;

  typedef struct packed {
    logic              opcode;
    logic [MAG_W-1:0]  magnitude_a;
    logic [ANG_W-1:0]  angle_a;
    logic [MAG_W-1:0]  magnitude_b;
    logic [ANG_W-1:0]  angle_b;
  } pva_in_t;

  typedef struct packed {
    logic [RMAG_W-1:0] result_magnitude;
    logic [ANG_W-1:0]  result_angle;
  } pva_out_t;

  typedef struct packed {
    logic                 opcode;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] yb;
  } pva_rect_t;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_pos;
    logic y_pos;
  } pva_flags_t;

  typedef struct packed {
    logic signed [VW-1:0]   vx;
    logic signed [ZV_W-1:0] z;
    pva_flags_t             flags;
  } pva_polar_t;

  function automatic logic [AT_W-1:0] pva_atan(input int unsigned i);
    logic [AT_W-1:0] r;
    case (i)
      0:       r = 30'd536870912;
      1:       r = 30'd316933406;
      2:       r = 30'd167458907;
      3:       r = 30'd85004756;
      4:       r = 30'd42667331;
      5:       r = 30'd21354465;
      6:       r = 30'd10680862;
      7:       r = 30'd5340245;
      8:       r = 30'd2670163;
      9:       r = 30'd1335087;
      10:      r = 30'd667544;
      11:      r = 30'd333772;
      12:      r = 30'd166886;
      13:      r = 30'd83443;
      14:      r = 30'd41721;
      15:      r = 30'd20860;
      16:      r = 30'd10430;
      17:      r = 30'd5215;
      18:      r = 30'd2607;
      19:      r = 30'd1303;
      20:      r = 30'd651;
      21:      r = 30'd325;
      22:      r = 30'd162;
      23:      r = 30'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // combined gain of two n-stage cordic passes, q2.30
  function automatic logic [63:0] pva_gain(input int unsigned n);
    logic [63:0] g;
    g = 64'd1 << 30;
    for (int unsigned i = 0; i < n; i++) begin
      g = g + (g >> (2 * i));
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// File: src/pva_stream_if.sv
// ----------------------------------------------------------------------------
// pva_stream_if
// valid/ready channel carrying one beat of payload
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/polar_vector_add_sub.sv
// ----------------------------------------------------------------------------
// polar_vector_add_sub
// adds or subtracts two polar vectors through rectangular form
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while the output is not stalled, every stage register has its own valid bit
// a stalled output only holds stages that are full, bubbles still fill
// reset clears all valid bits, payload registers are not reset
`default_nettype none

module polar_vector_add_sub import pva_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pva_stream_if.sink   in_i,
  pva_stream_if.source out_o
);

  logic       r_valid;
  logic       r_ready;
  pva_rect_t  r_data;
  logic       p_valid;
  logic       p_ready;
  pva_polar_t p_data;
  pva_out_t   o_data;

  pva_rotate #(.STAGES(CORDIC_STAGES)) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .out_valid_o (r_valid),
    .out_ready_i (r_ready),
    .out_data_o  (r_data)
  );

  pva_vector #(.STAGES(CORDIC_STAGES)) u_vector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r_valid),
    .in_ready_o  (r_ready),
    .in_data_i   (r_data),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_data_o  (p_data)
  );

  pva_scale #(.STAGES(CORDIC_STAGES)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .in_data_i   (p_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (o_data)
  );

  assign out_o.data = o_data;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("pipeline empty at output but input not ready");

  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("output draining but input not ready");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_o.valid)
    else $error("result beat valid right after reset");

  a_internal_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !p_valid |-> r_ready)
    else $error("vector stage empty but not ready");

endmodule

`default_nettype wire

// File: src/pva_rotate.sv
// ----------------------------------------------------------------------------
// pva_rotate
// quadrant fold and unrolled rotation cordic, one lane per input vector
// ----------------------------------------------------------------------------
`default_nettype none

module pva_rotate import pva_pkg::*; #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pva_in_t   in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output pva_rect_t      out_data_o
);

  logic [STAGES:0]   v_q;
  logic [STAGES+1:0] rdy;
  logic              op_q [0:STAGES];
  logic signed [CW-1:0]   x_q [0:1][0:STAGES];
  logic signed [CW-1:0]   y_q [0:1][0:STAGES];
  logic signed [ZR_W-1:0] z_q [0:1][0:STAGES];

  assign rdy[STAGES+1] = out_ready_i;
  assign in_ready_o    = rdy[0];

  for (genvar k = 0; k <= STAGES; k++) begin : g_stage
    assign rdy[k] = !v_q[k] || rdy[k+1];
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= in_valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && in_valid_i) begin
          op_q[k] <= in_data_i.opcode;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_q[k-1]) begin
          op_q[k] <= op_q[k-1];
        end
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (k == 0) begin : g_fold
        logic [MAG_W-1:0]     mag;
        logic [ANG_W-1:0]     ang;
        logic [ANG_W-1:0]     ang_f;
        logic signed [CW-1:0] x0;
        logic                 fold;

        assign mag   = (l == 0) ? in_data_i.magnitude_a : in_data_i.magnitude_b;
        assign ang   = (l == 0) ? in_data_i.angle_a : in_data_i.angle_b;
        assign fold  = ($signed(ang) > $signed(ANG_90)) || ($signed(ang) < $signed(ANG_270));
        assign ang_f = fold ? ang - ANG_180 : ang;
        assign x0    = $signed({{(CW-MAG_W-GUARD){1'b0}}, mag, {GUARD{1'b0}}});

        always_ff @(posedge clk_i) begin
          if (rdy[k] && in_valid_i) begin
            x_q[l][k] <= fold ? -x0 : x0;
            y_q[l][k] <= '0;
            z_q[l][k] <= $signed({{(ZR_W-ANG_W-16){ang_f[ANG_W-1]}}, ang_f, 16'b0});
          end
        end
      end else begin : g_iter
        localparam int unsigned I = k - 1;
        localparam logic signed [ZR_W-1:0] AT = $signed(ZR_W'(pva_atan(I)));
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        assign dx = y_q[l][k-1] >>> I;
        assign dy = x_q[l][k-1] >>> I;

        always_ff @(posedge clk_i) begin
          if (rdy[k] && v_q[k-1]) begin
            if (!z_q[l][k-1][ZR_W-1]) begin
              x_q[l][k] <= x_q[l][k-1] - dx;
              y_q[l][k] <= y_q[l][k-1] + dy;
              z_q[l][k] <= z_q[l][k-1] - AT;
            end else begin
              x_q[l][k] <= x_q[l][k-1] + dx;
              y_q[l][k] <= y_q[l][k-1] - dy;
              z_q[l][k] <= z_q[l][k-1] + AT;
            end
          end
        end
      end
    end
  end

  assign out_valid_o       = v_q[STAGES];
  assign out_data_o.opcode = op_q[STAGES];
  assign out_data_o.xa     = x_q[0][STAGES];
  assign out_data_o.ya     = y_q[0][STAGES];
  assign out_data_o.xb     = x_q[1][STAGES];
  assign out_data_o.yb     = y_q[1][STAGES];

endmodule

`default_nettype wire

// File: src/pva_vector.sv
// ----------------------------------------------------------------------------
// pva_vector
// component add/sub, half-plane fold and unrolled vectoring cordic
// ----------------------------------------------------------------------------
`default_nettype none

module pva_vector import pva_pkg::*; #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire pva_rect_t  in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output pva_polar_t      out_data_o
);

  localparam int unsigned LAST = STAGES + 1;

  logic [LAST:0]   v_q;
  logic [LAST+1:0] rdy;
  logic signed [VW-1:0]   x_q [0:LAST];
  logic signed [VW-1:0]   y_q [0:LAST];
  logic signed [ZV_W-1:0] z_q [0:LAST];
  pva_flags_t             f_q [0:LAST];

  assign rdy[LAST+1] = out_ready_i;
  assign in_ready_o  = rdy[0];

  for (genvar k = 0; k <= LAST; k++) begin : g_stage
    assign rdy[k] = !v_q[k] || rdy[k+1];
    if (k == 0) begin : g_sum
      logic signed [SW-1:0] sx;
      logic signed [SW-1:0] sy;

      assign sx = in_data_i.opcode ? SW'(in_data_i.xa) - SW'(in_data_i.xb)
                                   : SW'(in_data_i.xa) + SW'(in_data_i.xb);
      assign sy = in_data_i.opcode ? SW'(in_data_i.ya) - SW'(in_data_i.yb)
                                   : SW'(in_data_i.ya) + SW'(in_data_i.yb);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= in_valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[k] && in_valid_i) begin
          x_q[k] <= VW'(sx);
          y_q[k] <= VW'(sy);
          z_q[k] <= '0;
          f_q[k] <= '0;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (k == 1) begin : g_fold
        pva_flags_t fl;
        logic       neg;

        assign neg       = x_q[k-1][VW-1];
        assign fl.x_zero = (x_q[k-1] == '0);
        assign fl.y_zero = (y_q[k-1] == '0);
        assign fl.x_pos  = !neg && !fl.x_zero;
        assign fl.y_pos  = !y_q[k-1][VW-1] && !fl.y_zero;

        always_ff @(posedge clk_i) begin
          if (rdy[k] && v_q[k-1]) begin
            x_q[k] <= neg ? -x_q[k-1] : x_q[k-1];
            y_q[k] <= neg ? -y_q[k-1] : y_q[k-1];
            z_q[k] <= neg ? $signed(ZV_W'(1) << 31) : '0;
            f_q[k] <= fl;
          end
        end
      end else begin : g_iter
        localparam int unsigned I = k - 2;
        localparam logic signed [ZV_W-1:0] AT = $signed(ZV_W'(pva_atan(I)));
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;

        assign dx = y_q[k-1] >>> I;
        assign dy = x_q[k-1] >>> I;

        always_ff @(posedge clk_i) begin
          if (rdy[k] && v_q[k-1]) begin
            f_q[k] <= f_q[k-1];
            if (y_q[k-1][VW-1]) begin
              x_q[k] <= x_q[k-1] - dx;
              y_q[k] <= y_q[k-1] + dy;
              z_q[k] <= z_q[k-1] - AT;
            end else begin
              x_q[k] <= x_q[k-1] + dx;
              y_q[k] <= y_q[k-1] - dy;
              z_q[k] <= z_q[k-1] + AT;
            end
          end
        end
      end
    end
  end

  assign out_valid_o      = v_q[LAST];
  assign out_data_o.vx    = x_q[LAST];
  assign out_data_o.z     = z_q[LAST];
  assign out_data_o.flags = f_q[LAST];

endmodule

`default_nettype wire

// File: src/pva_scale.sv
// ----------------------------------------------------------------------------
// pva_scale
// gain correction by split multiply, rounding, saturation and angle select
// ----------------------------------------------------------------------------
`default_nettype none

module pva_scale import pva_pkg::*; #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire pva_polar_t  in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pva_out_t         out_data_o
);

  localparam logic [63:0] GAIN = pva_gain(STAGES);
  localparam logic [31:0] INV  = 32'((64'd1 << 62) / GAIN);
  localparam int unsigned HI_W = MAGC_W - LO_W;
  localparam int unsigned FW   = MAGC_W + 33;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic [LO_W+31:0]   lo_q;
  logic [HI_W+31:0]   hi_q;
  logic [ANG_W-1:0]   ang_q;
  pva_out_t           res_q;

  logic [MAGC_W-1:0]  mag;
  logic [ZV_W-1:0]    zr;
  logic [ANG_W-1:0]   ang_d;
  logic [FW-1:0]      full;
  logic [FW-39:0]     rnd;
  logic [RMAG_W-1:0]  mag_d;

  assign rdy[2]     = out_ready_i;
  assign rdy[1]     = !v_q[1] || rdy[2];
  assign rdy[0]     = !v_q[0] || rdy[1];
  assign in_ready_o = rdy[0];

  assign mag = in_data_i.vx[VW-1] ? '0 : in_data_i.vx[MAGC_W-1:0];
  assign zr  = in_data_i.z + ZV_W'(16'h8000);

  always_comb begin
    if (in_data_i.flags.x_zero && in_data_i.flags.y_zero) begin
      ang_d = ANG_0;
    end else if (in_data_i.flags.x_zero) begin
      ang_d = in_data_i.flags.y_pos ? ANG_90 : ANG_270;
    end else if (in_data_i.flags.y_zero) begin
      ang_d = in_data_i.flags.x_pos ? ANG_0 : ANG_180;
    end else begin
      ang_d = zr[31:16];
    end
  end

  assign full  = {hi_q, {LO_W{1'b0}}} + FW'(lo_q) + (FW'(1) << 37);
  assign rnd   = full[FW-1:38];
  assign mag_d = (rnd > FW'(2 ** RMAG_W - 1)) ? {RMAG_W{1'b1}} : rnd[RMAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (rdy[1]) begin
        v_q[1] <= v_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      lo_q  <= mag[LO_W-1:0] * INV;
      hi_q  <= mag[MAGC_W-1:LO_W] * INV;
      ang_q <= ang_d;
    end
    if (rdy[1] && v_q[0]) begin
      res_q.result_magnitude <= mag_d;
      res_q.result_angle     <= ang_q;
    end
  end

  assign out_valid_o = v_q[1];
  assign out_data_o  = res_q;

endmodule

`default_nettype wire
